// File: hw/rtl/oost_pkg.sv
// ----------------------------------------------------------------------------
// oost_pkg
// Types and codes shared by the out-of-sync page table tracker.
// ----------------------------------------------------------------------------
package oost_pkg;

	localparam int PAGE_W = 40;
	localparam int OFF_W  = 12;
	localparam int BUF_W  = 3;

	// operation codes
	localparam logic [2:0] FUNC_ADD_PAGE   = 3'd0;
	localparam logic [2:0] FUNC_ADD_FIXUP  = 3'd1;
	localparam logic [2:0] FUNC_REMOVE     = 3'd2;
	localparam logic [2:0] FUNC_LOOKUP     = 3'd3;
	localparam logic [2:0] FUNC_RESYNC     = 3'd4;
	localparam logic [2:0] FUNC_RESYNC_ALL = 3'd5;

	// result kinds
	localparam logic [2:0] KIND_RM_MAP    = 3'd0;
	localparam logic [2:0] KIND_RESYNC    = 3'd1;
	localparam logic [2:0] KIND_COPY      = 3'd2;
	localparam logic [2:0] KIND_LOOKUP    = 3'd3;
	localparam logic [2:0] KIND_NOT_FOUND = 3'd4;
	localparam logic [2:0] KIND_DONE      = 3'd5;

	typedef struct packed {
		logic [2:0]        func;
		logic [PAGE_W-1:0] page;
		logic [PAGE_W-1:0] shadow_page;
		logic [OFF_W-1:0]  offset;
	} req_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [PAGE_W-1:0] out_page;
		logic [PAGE_W-1:0] out_shadow_page;
		logic [OFF_W-1:0]  out_offset;
		logic [BUF_W-1:0]  buffer;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic [PAGE_W-1:0] frame;
		logic [OFF_W-1:0]  offset;
	} fixup_t;

endpackage

// File: hw/rtl/oost_res.sv
// ----------------------------------------------------------------------------
// oost_res
// Page number modulo slot count, one byte per cycle.
// ----------------------------------------------------------------------------
module oost_res
	import oost_pkg::*;
#(
	parameter int TABLE_SLOTS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  logic [PAGE_W-1:0]              value,
	output logic                           done,
	output logic [$clog2(TABLE_SLOTS)-1:0] res
);
	localparam int SW = $clog2(TABLE_SLOTS);

	logic [SW-1:0]     r_q;
	logic [PAGE_W-1:0] sh_q;
	logic [2:0]        cnt_q;
	logic              run_q;
	logic [SW-1:0]     r_next;

	always_comb begin
		logic [SW:0] t;
		r_next = r_q;
		for (int b = 0; b < 8; b++) begin
			t = {r_next, sh_q[PAGE_W-1-b]};
			if (t >= (SW+1)'(TABLE_SLOTS)) begin
				t = t - (SW+1)'(TABLE_SLOTS);
			end
			r_next = t[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd4) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			r_q  <= '0;
			sh_q <= value;
		end else if (run_q) begin
			r_q  <= r_next;
			sh_q <= sh_q << 8;
		end
	end

	assign done = run_q && (cnt_q == 3'd4);
	assign res  = r_next;

endmodule

// File: hw/rtl/oost_ram.sv
// ----------------------------------------------------------------------------
// oost_ram
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module oost_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/out_of_sync_page_table_tracker_unit.sv
// ----------------------------------------------------------------------------
// out_of_sync_page_table_tracker_unit
// Tracks out-of-sync guest page-table frames in a small open-addressed table
// with a fixup ring per slot, and issues resync / unmap / copy commands.
// ----------------------------------------------------------------------------
//  channel | ports                 | transfer
//  --------+-----------------------+-------------------------------------
//  request | start, busy, req      | start high while busy low
//  result  | strobe, rsp           | every cycle strobe is high
//
//  Every request first passes through the byte-serial modulo unit that
//  finds the home slot, then through a dispatch state. Lookup and remove
//  then probe the home slot and the next one; add fixup, resync page,
//  each evicted or resync-all slot and a punt on add walk every fixup of
//  the slot in turn, and resync all scans the slots up to the last valid
//  one; the single read port of each memory makes these walks serial.
//  Results leave one a cycle.
//  Reset clears all valid bits at once; no clearing pass is needed.
//  Results cannot be stalled; busy holds off new requests.
// ----------------------------------------------------------------------------
module out_of_sync_page_table_tracker_unit
	import oost_pkg::*;
#(
	parameter int TABLE_SLOTS     = 4,
	parameter int FIXUPS_PER_SLOT = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic strobe,
	output rsp_t rsp
);
	localparam int SW  = $clog2(TABLE_SLOTS);
	localparam int FW  = (FIXUPS_PER_SLOT > 1) ? $clog2(FIXUPS_PER_SLOT) : 1;
	localparam int NF  = TABLE_SLOTS * FIXUPS_PER_SLOT;
	localparam int FAW = $clog2(NF);
	localparam int FXW = PAGE_W + OFF_W;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_MOD    = 5'd1;
	localparam logic [4:0] S_DISP   = 5'd2;
	localparam logic [4:0] S_FH     = 5'd3;
	localparam logic [4:0] S_FN     = 5'd4;
	localparam logic [4:0] S_FOUND  = 5'd5;
	localparam logic [4:0] S_AF_RD  = 5'd6;
	localparam logic [4:0] S_AF_CK  = 5'd7;
	localparam logic [4:0] S_AF_WR  = 5'd8;
	localparam logic [4:0] S_RS_PG  = 5'd9;
	localparam logic [4:0] S_RS_RD  = 5'd10;
	localparam logic [4:0] S_RS_EM  = 5'd11;
	localparam logic [4:0] S_RS_END = 5'd12;
	localparam logic [4:0] S_AP     = 5'd13;
	localparam logic [4:0] S_MV_PG  = 5'd14;
	localparam logic [4:0] S_MV_RD  = 5'd15;
	localparam logic [4:0] S_MV_WR  = 5'd16;
	localparam logic [4:0] S_AP_FIN = 5'd17;
	localparam logic [4:0] S_ALL    = 5'd18;

	localparam logic [1:0] RET_LAST = 2'd0;
	localparam logic [1:0] RET_ADD  = 2'd1;
	localparam logic [1:0] RET_ALL  = 2'd2;

	logic [4:0]        state_q;
	req_t              op_q;
	logic [SW-1:0]     h_q, dst_q, s_q, rs_q, all_q;
	logic [FW-1:0]     k_q;
	logic              swap_q, dup_q, oldv_q;
	fixup_t            old_q;
	logic [PAGE_W-1:0] rpage_q;
	logic [1:0]        ret_q;
	logic [TABLE_SLOTS-1:0] valid_q, home_q;
	logic [NF-1:0]     fv_q;
	logic [FW-1:0]     next_q [TABLE_SLOTS];
	logic [BUF_W-1:0]  buf_q  [TABLE_SLOTS];
	rsp_t              rsp_q;
	logic              strobe_q;

	logic              res_done;
	logic [SW-1:0]     res;
	logic [SW-1:0]     nxt_h, dst_c;
	logic              k_end, above;

	logic              pg_we;
	logic [SW-1:0]     pg_waddr, pg_raddr;
	logic [PAGE_W-1:0] pg_wdata, pg_rdata;
	logic              fx_we;
	logic [FAW-1:0]    fx_waddr, fx_raddr;
	fixup_t            fx_wdata, fx_rdata;
	logic [FXW-1:0]    fx_rraw;

	function automatic logic [FAW-1:0] fidx(input logic [SW-1:0] s, input logic [FW-1:0] k);
		return FAW'(int'(s) * FIXUPS_PER_SLOT + int'(k));
	endfunction

	function automatic rsp_t mk(input logic [2:0] kind, input logic [PAGE_W-1:0] pg,
		input fixup_t fx, input logic [BUF_W-1:0] b, input logic last);
		rsp_t r;
		r.kind            = kind;
		r.out_page        = pg;
		r.out_shadow_page = fx.frame;
		r.out_offset      = fx.offset;
		r.buffer          = b;
		r.last            = last;
		return r;
	endfunction

	oost_res #(.TABLE_SLOTS(TABLE_SLOTS)) u_res (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (state_q == S_IDLE && start),
		.value  (req.page),
		.done   (res_done),
		.res    (res)
	);

	oost_ram #(.WIDTH(PAGE_W), .DEPTH(TABLE_SLOTS)) u_page_ram (
		.clk   (clk),
		.we    (pg_we),
		.waddr (pg_waddr),
		.wdata (pg_wdata),
		.raddr (pg_raddr),
		.rdata (pg_rdata)
	);

	oost_ram #(.WIDTH(FXW), .DEPTH(NF)) u_fixup_ram (
		.clk   (clk),
		.we    (fx_we),
		.waddr (fx_waddr),
		.wdata (fx_wdata),
		.raddr (fx_raddr),
		.rdata (fx_rraw)
	);
	assign fx_rdata = fixup_t'(fx_rraw);

	assign nxt_h = (h_q == SW'(TABLE_SLOTS - 1)) ? '0 : h_q + SW'(1);
	assign dst_c = (valid_q[h_q] && home_q[h_q]) ? nxt_h : h_q;
	assign k_end = (k_q == FW'(FIXUPS_PER_SLOT - 1));

	always_comb begin
		above = 1'b0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			if (i > int'(rs_q) && valid_q[i]) begin
				above = 1'b1;
			end
		end
	end

	// memory ports
	always_comb begin
		pg_raddr = h_q;
		unique case (state_q)
			S_DISP:  pg_raddr = (op_q.func == FUNC_ADD_PAGE) ? dst_c : h_q;
			S_FH:    pg_raddr = nxt_h;
			S_ALL:   pg_raddr = all_q;
			default: pg_raddr = h_q;
		endcase
		pg_we    = 1'b0;
		pg_waddr = h_q;
		pg_wdata = op_q.page;
		if (state_q == S_MV_PG) begin
			pg_we    = 1'b1;
			pg_waddr = dst_q;
			pg_wdata = pg_rdata;
		end else if ((state_q == S_AP && !swap_q) || state_q == S_AP_FIN) begin
			pg_we = 1'b1;
		end

		unique case (state_q)
			S_AF_RD: fx_raddr = fidx(s_q, k_q);
			S_RS_RD: fx_raddr = fidx(rs_q, k_q);
			S_MV_RD: fx_raddr = fidx(h_q, k_q);
			default: fx_raddr = '0;
		endcase
		fx_we           = 1'b0;
		fx_waddr        = fidx(s_q, next_q[s_q]);
		fx_wdata.frame  = op_q.shadow_page;
		fx_wdata.offset = op_q.offset;
		if (state_q == S_AF_WR && !dup_q) begin
			fx_we = 1'b1;
		end else if (state_q == S_MV_WR) begin
			fx_we    = 1'b1;
			fx_waddr = fidx(dst_q, k_q);
			fx_wdata = fx_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
			valid_q  <= '0;
			home_q   <= '0;
			fv_q     <= '0;
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				next_q[i] <= '0;
				buf_q[i]  <= BUF_W'(i);
			end
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (res_done) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					priority case (op_q.func)
						FUNC_ADD_PAGE: begin
							swap_q <= valid_q[h_q] && home_q[h_q];
							dst_q  <= dst_c;
							if (valid_q[dst_c]) begin
								rs_q    <= dst_c;
								ret_q   <= RET_ADD;
								state_q <= S_RS_PG;
							end else begin
								state_q <= S_AP;
							end
						end
						FUNC_ADD_FIXUP, FUNC_REMOVE, FUNC_LOOKUP, FUNC_RESYNC: begin
							state_q <= S_FH;
						end
						FUNC_RESYNC_ALL: begin
							all_q <= '0;
							if (|valid_q) begin
								state_q <= S_ALL;
							end else begin
								strobe_q <= 1'b1;
								state_q  <= S_IDLE;
							end
						end
						default: begin
							strobe_q <= 1'b1;
							state_q  <= S_IDLE;
						end
					endcase
				end
				S_FH: begin
					if (valid_q[h_q] && pg_rdata == op_q.page) begin
						s_q     <= h_q;
						state_q <= S_FOUND;
					end else begin
						state_q <= S_FN;
					end
				end
				S_FN: begin
					if (valid_q[nxt_h] && pg_rdata == op_q.page) begin
						s_q     <= nxt_h;
						state_q <= S_FOUND;
					end else begin
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_FOUND: begin
					priority case (op_q.func)
						FUNC_REMOVE: begin
							valid_q[s_q] <= 1'b0;
							strobe_q     <= 1'b1;
							state_q      <= S_IDLE;
						end
						FUNC_LOOKUP: begin
							strobe_q <= 1'b1;
							state_q  <= S_IDLE;
						end
						FUNC_RESYNC: begin
							rs_q    <= s_q;
							rpage_q <= op_q.page;
							ret_q   <= RET_LAST;
							k_q     <= '0;
							state_q <= S_RS_RD;
						end
						default: begin
							k_q     <= '0;
							dup_q   <= 1'b0;
							oldv_q  <= 1'b0;
							state_q <= S_AF_RD;
						end
					endcase
				end
				S_AF_RD: state_q <= S_AF_CK;
				S_AF_CK: begin
					if (fv_q[fidx(s_q, k_q)] && fx_rdata.frame == op_q.shadow_page
						&& fx_rdata.offset == op_q.offset) begin
						dup_q <= 1'b1;
					end
					if (k_q == next_q[s_q]) begin
						old_q  <= fx_rdata;
						oldv_q <= fv_q[fidx(s_q, k_q)];
					end
					if (k_end) begin
						state_q <= S_AF_WR;
					end else begin
						k_q     <= k_q + FW'(1);
						state_q <= S_AF_RD;
					end
				end
				S_AF_WR: begin
					if (!dup_q) begin
						fv_q[fidx(s_q, next_q[s_q])] <= 1'b1;
						next_q[s_q] <= (next_q[s_q] == FW'(FIXUPS_PER_SLOT - 1)) ? '0
							: next_q[s_q] + FW'(1);
					end
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_RS_PG: begin
					rpage_q <= pg_rdata;
					k_q     <= '0;
					state_q <= S_RS_RD;
				end
				S_RS_RD: state_q <= S_RS_EM;
				S_RS_EM: begin
					if (fv_q[fidx(rs_q, k_q)]) begin
						fv_q[fidx(rs_q, k_q)] <= 1'b0;
						strobe_q <= 1'b1;
					end
					if (k_end) begin
						state_q <= S_RS_END;
					end else begin
						k_q     <= k_q + FW'(1);
						state_q <= S_RS_RD;
					end
				end
				S_RS_END: begin
					valid_q[rs_q] <= 1'b0;
					strobe_q      <= 1'b1;
					unique case (ret_q)
						RET_ADD: state_q <= S_AP;
						RET_ALL: begin
							all_q   <= rs_q + SW'(1);
							state_q <= above ? S_ALL : S_IDLE;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_ALL: begin
					if (valid_q[all_q]) begin
						rs_q    <= all_q;
						ret_q   <= RET_ALL;
						state_q <= S_RS_PG;
					end else begin
						all_q <= all_q + SW'(1);
					end
				end
				S_AP: begin
					if (swap_q) begin
						state_q <= S_MV_PG;
					end else begin
						valid_q[h_q] <= 1'b1;
						home_q[h_q]  <= 1'b1;
						next_q[h_q]  <= '0;
						for (int k = 0; k < FIXUPS_PER_SLOT; k++) begin
							fv_q[fidx(h_q, FW'(k))] <= 1'b0;
						end
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_MV_PG: begin
					k_q     <= '0;
					state_q <= S_MV_RD;
				end
				S_MV_RD: state_q <= S_MV_WR;
				S_MV_WR: begin
					fv_q[fidx(dst_q, k_q)] <= fv_q[fidx(h_q, k_q)];
					fv_q[fidx(h_q, k_q)]   <= 1'b0;
					if (k_end) begin
						state_q <= S_AP_FIN;
					end else begin
						k_q     <= k_q + FW'(1);
						state_q <= S_MV_RD;
					end
				end
				S_AP_FIN: begin
					valid_q[h_q]   <= 1'b1;
					valid_q[dst_q] <= 1'b1;
					home_q[h_q]    <= 1'b1;
					home_q[dst_q]  <= 1'b0;
					next_q[dst_q]  <= next_q[h_q];
					next_q[h_q]    <= '0;
					buf_q[h_q]     <= buf_q[dst_q];
					buf_q[dst_q]   <= buf_q[h_q];
					strobe_q       <= 1'b1;
					state_q        <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload of the request and of each result
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q <= req;
		end
		if (state_q == S_MOD && res_done) begin
			h_q <= res;
		end
		unique case (state_q)
			S_DISP:   rsp_q <= mk(KIND_DONE, '0, '0, '0, 1'b1);
			S_FN:     rsp_q <= mk(KIND_NOT_FOUND, op_q.page, '0, '0, 1'b1);
			S_FOUND: begin
				if (op_q.func == FUNC_LOOKUP) begin
					rsp_q <= mk(KIND_LOOKUP, op_q.page, '0, buf_q[s_q], 1'b1);
				end else begin
					rsp_q <= mk(KIND_DONE, '0, '0, '0, 1'b1);
				end
			end
			S_AF_WR: begin
				if (!dup_q && oldv_q) begin
					rsp_q <= mk(KIND_RM_MAP, op_q.page, old_q, '0, 1'b1);
				end else begin
					rsp_q <= mk(KIND_DONE, '0, '0, '0, 1'b1);
				end
			end
			S_RS_EM:  rsp_q <= mk(KIND_RM_MAP, rpage_q, fx_rdata, '0, 1'b0);
			S_RS_END: rsp_q <= mk(KIND_RESYNC, rpage_q, '0, buf_q[rs_q],
				(ret_q == RET_LAST) || (ret_q == RET_ALL && !above));
			S_AP:     rsp_q <= mk(KIND_COPY, op_q.page, '0, buf_q[h_q], 1'b1);
			S_AP_FIN: rsp_q <= mk(KIND_COPY, op_q.page, '0, buf_q[dst_q], 1'b1);
			default:  rsp_q <= rsp_q;
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign rsp    = rsp_q;

endmodule

// File: hw/rtl/oost_checker.sv
// ----------------------------------------------------------------------------
// oost_checker
// Port-level checks for the out-of-sync page table tracker.
// ----------------------------------------------------------------------------
module oost_checker
	import oost_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input rsp_t rsp
);

	// an accepted transfer keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	// more results pending: the block cannot be idle
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !rsp.last) |-> busy)
		else $error("non-final result while idle");

	// a final result never runs straight into another one
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && rsp.last) |=> !strobe)
		else $error("result right after a final result");

	// done and not-found answers stand alone
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (rsp.kind == KIND_DONE || rsp.kind == KIND_NOT_FOUND)) |-> rsp.last)
		else $error("done or not-found answer not final");

endmodule

bind out_of_sync_page_table_tracker_unit oost_checker u_oost_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.strobe (strobe),
	.rsp    (rsp)
);

// File: tb/oost_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oost_scoreboard
// Watches the request and result channels of the out-of-sync tracker, keeps
// its own copy of the table, predicts the commands for every transfer and
// compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module oost_scoreboard
	import oost_pkg::*;
#(
	parameter int TABLE_SLOTS     = 4,
	parameter int FIXUPS_PER_SLOT = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t req,
	input  logic strobe,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending,
	output int   req_count,
	output int   rsp_count
);

	localparam int NFIX = TABLE_SLOTS * FIXUPS_PER_SLOT;

	logic              tab_valid [TABLE_SLOTS];
	logic [PAGE_W-1:0] tab_page  [TABLE_SLOTS];
	logic [BUF_W-1:0]  tab_buf   [TABLE_SLOTS];
	logic              fx_valid  [NFIX];
	fixup_t            fx        [NFIX];
	int                fx_next   [TABLE_SLOTS];
	rsp_t              cmd_q[$];

	assign pending = cmd_q.size();

	function automatic rsp_t mk_cmd(logic [2:0] k, logic [PAGE_W-1:0] pg,
			logic [PAGE_W-1:0] sp, logic [OFF_W-1:0] off, logic [BUF_W-1:0] b);
		rsp_t r;
		r.kind = k;
		r.out_page = pg;
		r.out_shadow_page = sp;
		r.out_offset = off;
		r.buffer = b;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic int find_slot(logic [PAGE_W-1:0] pg);
		int h;
		h = int'(pg % TABLE_SLOTS);
		if (tab_valid[h] && tab_page[h] == pg) return h;
		h = (h + 1) % TABLE_SLOTS;
		if (tab_valid[h] && tab_page[h] == pg) return h;
		return -1;
	endfunction

	task automatic resync_slot(int s, ref rsp_t cmds[$]);
		int f;
		for (int k = 0; k < FIXUPS_PER_SLOT; k++) begin
			f = s * FIXUPS_PER_SLOT + k;
			if (fx_valid[f]) begin
				cmds.push_back(mk_cmd(KIND_RM_MAP, tab_page[s], fx[f].frame,
					fx[f].offset, '0));
				fx_valid[f] = 1'b0;
			end
		end
		cmds.push_back(mk_cmd(KIND_RESYNC, tab_page[s], '0, '0, tab_buf[s]));
		tab_valid[s] = 1'b0;
	endtask

	task automatic add_page(logic [PAGE_W-1:0] pg, ref rsp_t cmds[$]);
		int home, dst, carry_next, f;
		logic [PAGE_W-1:0] carry_page;
		logic   cv [FIXUPS_PER_SLOT];
		fixup_t cf [FIXUPS_PER_SLOT];
		logic   swapped;
		logic [BUF_W-1:0] t;
		home = int'(pg % TABLE_SLOTS);
		dst = home;
		carry_page = pg;
		carry_next = 0;
		swapped = 1'b0;
		for (int k = 0; k < FIXUPS_PER_SLOT; k++) begin
			cv[k] = 1'b0;
			cf[k] = '0;
		end
		if (tab_valid[home] && int'(tab_page[home] % TABLE_SLOTS) == home) begin
			// punt the rightful occupant with its fixups to the next slot
			carry_page = tab_page[home];
			carry_next = fx_next[home];
			for (int k = 0; k < FIXUPS_PER_SLOT; k++) begin
				f = home * FIXUPS_PER_SLOT + k;
				cv[k] = fx_valid[f];
				cf[k] = fx[f];
				fx_valid[f] = 1'b0;
				fx[f] = '0;
			end
			tab_page[home] = pg;
			fx_next[home] = 0;
			swapped = 1'b1;
			dst = (home + 1) % TABLE_SLOTS;
		end
		if (tab_valid[dst]) resync_slot(dst, cmds);
		tab_valid[dst] = 1'b1;
		tab_page[dst] = carry_page;
		fx_next[dst] = carry_next;
		for (int k = 0; k < FIXUPS_PER_SLOT; k++) begin
			f = dst * FIXUPS_PER_SLOT + k;
			fx_valid[f] = cv[k];
			fx[f] = cf[k];
		end
		if (swapped) begin
			t = tab_buf[dst];
			tab_buf[dst] = tab_buf[home];
			tab_buf[home] = t;
		end
		cmds.push_back(mk_cmd(KIND_COPY, tab_page[home], '0, '0, tab_buf[home]));
	endtask

	task automatic add_fixup(req_t r, ref rsp_t cmds[$]);
		int s, nx, f;
		s = find_slot(r.page);
		if (s < 0) begin
			cmds.push_back(mk_cmd(KIND_NOT_FOUND, r.page, '0, '0, '0));
			return;
		end
		for (int k = 0; k < FIXUPS_PER_SLOT; k++) begin
			f = s * FIXUPS_PER_SLOT + k;
			if (fx_valid[f] && fx[f].frame == r.shadow_page && fx[f].offset == r.offset)
				return;
		end
		nx = fx_next[s] % FIXUPS_PER_SLOT;
		f = s * FIXUPS_PER_SLOT + nx;
		if (fx_valid[f])
			cmds.push_back(mk_cmd(KIND_RM_MAP, r.page, fx[f].frame, fx[f].offset, '0));
		fx_valid[f] = 1'b1;
		fx[f].frame = r.shadow_page;
		fx[f].offset = r.offset;
		fx_next[s] = (nx + 1) % FIXUPS_PER_SLOT;
	endtask

	task automatic predict(req_t r);
		rsp_t cmds[$];
		int s;
		case (r.func)
			FUNC_ADD_PAGE: add_page(r.page, cmds);
			FUNC_ADD_FIXUP: add_fixup(r, cmds);
			FUNC_REMOVE: begin
				s = find_slot(r.page);
				if (s < 0) cmds.push_back(mk_cmd(KIND_NOT_FOUND, r.page, '0, '0, '0));
				else tab_valid[s] = 1'b0;
			end
			FUNC_LOOKUP: begin
				s = find_slot(r.page);
				if (s < 0) cmds.push_back(mk_cmd(KIND_NOT_FOUND, r.page, '0, '0, '0));
				else cmds.push_back(mk_cmd(KIND_LOOKUP, r.page, '0, '0, tab_buf[s]));
			end
			FUNC_RESYNC: begin
				s = find_slot(r.page);
				if (s < 0) cmds.push_back(mk_cmd(KIND_NOT_FOUND, r.page, '0, '0, '0));
				else resync_slot(s, cmds);
			end
			FUNC_RESYNC_ALL: begin
				for (int i = 0; i < TABLE_SLOTS; i++)
					if (tab_valid[i]) resync_slot(i, cmds);
			end
			default: ;
		endcase
		if (cmds.size() == 0) cmds.push_back(mk_cmd(KIND_DONE, '0, '0, '0, '0));
		cmds[cmds.size() - 1].last = 1'b1;
		foreach (cmds[i]) cmd_q.push_back(cmds[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				tab_valid[i] = 1'b0;
				tab_page[i] = '0;
				tab_buf[i] = BUF_W'(i);
				fx_next[i] = 0;
			end
			for (int i = 0; i < NFIX; i++) begin
				fx_valid[i] = 1'b0;
				fx[i] = '0;
			end
			cmd_q.delete();
			fail_count <= 0;
			req_count <= 0;
			rsp_count <= 0;
		end else begin
			// results of this edge were caused by earlier transfers: check first
			if (strobe) begin
				rsp_count <= rsp_count + 1;
				if (cmd_q.size() == 0) begin
					$display("%0t: result without a pending command: got %p", $time, rsp);
					fail_count <= fail_count + 1;
				end else begin
					want = cmd_q.pop_front();
					if (rsp !== want) begin
						$display("%0t: result mismatch: expected %p, actual %p",
							$time, want, rsp);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) begin
				req_count <= req_count + 1;
				predict(req);
			end
		end
	end

endmodule

// File: tb/out_of_sync_page_table_tracker_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// out_of_sync_page_table_tracker_unit_test
// Drives directed and random page-table operations into the tracker with
// random gaps; the checker beside it predicts and compares every command.
// ----------------------------------------------------------------------------
module out_of_sync_page_table_tracker_unit_test;
	import oost_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic strobe;
	rsp_t rsp;
	int   fail_count, pending, req_count, rsp_count;
	int   gap_pct;
	logic [PAGE_W-1:0] pool [8];

	out_of_sync_page_table_tracker_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .strobe(strobe), .rsp(rsp)
	);

	oost_scoreboard u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.strobe(strobe), .rsp(rsp), .fail_count(fail_count), .pending(pending),
		.req_count(req_count), .rsp_count(rsp_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

	function automatic logic [PAGE_W-1:0] rand_page();
		return PAGE_W'({$urandom, $urandom});
	endfunction

	// hold start until the transfer happens, then at random drop it and idle
	task automatic send(logic [2:0] f, logic [PAGE_W-1:0] pg,
			logic [PAGE_W-1:0] sp, logic [OFF_W-1:0] off);
		req.func <= f;
		req.page <= pg;
		req.shadow_page <= sp;
		req.offset <= off;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// mostly pages from a small pool that collides on home slots
	task automatic rand_op();
		logic [PAGE_W-1:0] pg;
		int r;
		r = $urandom_range(99);
		pg = ($urandom_range(9) == 0) ? rand_page() : pool[$urandom_range(7)];
		if (r < 25) send(FUNC_ADD_PAGE, pg, '0, '0);
		else if (r < 60) send(FUNC_ADD_FIXUP, pg,
			($urandom_range(1) ? rand_page() : PAGE_W'($urandom_range(3))),
			($urandom_range(1) ? OFF_W'($urandom) : OFF_W'($urandom_range(1))));
		else if (r < 70) send(FUNC_REMOVE, pg, rand_page(), OFF_W'($urandom));
		else if (r < 82) send(FUNC_LOOKUP, pg, '0, '0);
		else if (r < 92) send(FUNC_RESYNC, pg, '0, '0);
		else if (r < 96) send(FUNC_RESYNC_ALL, pg, '0, '0);
		else send(3'($urandom_range(6, 7)), rand_page(), rand_page(), OFF_W'($urandom));
	endtask

	initial begin
		logic [PAGE_W-1:0] top;
		top = '1;
		start = 1'b0;
		req = '0;
		gap_pct = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: misses on empty table, punt and evict, ring wrap, resyncs
		send(FUNC_LOOKUP, 40'd4, '0, '0);
		send(FUNC_ADD_FIXUP, top, top, '1);
		send(FUNC_REMOVE, 40'd0, '0, '0);
		send(FUNC_RESYNC, 40'd1, '0, '0);
		send(FUNC_RESYNC_ALL, '0, '0, '0);
		send(FUNC_ADD_PAGE, 40'd4, '0, '0);
		send(FUNC_ADD_FIXUP, 40'd4, top, '1);
		send(FUNC_ADD_FIXUP, 40'd4, top, '1);
		send(FUNC_ADD_FIXUP, 40'd4, 40'd7, 12'd0);
		send(FUNC_ADD_FIXUP, 40'd4, 40'd9, 12'h800);
		send(FUNC_ADD_PAGE, 40'd5, '0, '0);
		send(FUNC_ADD_PAGE, 40'd8, '0, '0);
		send(FUNC_LOOKUP, 40'd4, '0, '0);
		send(FUNC_ADD_PAGE, top, '0, '0);
		send(FUNC_ADD_PAGE, top, '0, '0);
		send(FUNC_ADD_FIXUP, top, 40'h55_5555_5555, 12'hAAA);
		send(FUNC_RESYNC, 40'd8, '0, '0);
		send(FUNC_REMOVE, top, '0, '0);
		send(FUNC_LOOKUP, top, '0, '0);
		send(3'd6, top, top, '1);
		send(3'd7, '0, '0, '0);
		send(FUNC_RESYNC_ALL, '0, '0, '0);
		drain();

		for (int i = 0; i < 8; i++)
			pool[i] = (i < 6) ? PAGE_W'($urandom_range(11)) : rand_page();
		for (int ph = 0; ph < 3; ph++) begin
			gap_pct = (ph == 0) ? 13 : (ph == 1) ? 85 : 0;
			for (int i = 0; i < 105; i++) rand_op();
			drain();
		end

		repeat (50) @(posedge clk);
		$display("Covered %0d requests and %0d results, with punts, evictions,",
			req_count, rsp_count);
		$display("fixup ring wrap, resyncs and misses on a colliding page pool.");
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
